// File: hw/rtl/hrhp_pkg.sv
`default_nettype none

package hrhp_pkg;

  localparam int METHOD_LIMIT = 8;
  localparam int URL_LIMIT    = 64;
  localparam int GET_LEN      = 3;

  localparam int MCW = $clog2(METHOD_LIMIT + 2);
  localparam int UCW = $clog2(URL_LIMIT + 2);
  localparam int LENW = 7;

  localparam logic OP_NEW  = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_URL          = 3'd1;
  localparam logic [2:0] EV_DONE         = 3'd2;
  localparam logic [2:0] EV_DONE_BADPATH = 3'd3;
  localparam logic [2:0] EV_NOTALLOWED   = 3'd4;
  localparam logic [2:0] EV_BADREQ       = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [3:0] {
    ST_METHOD     = 4'd0,
    ST_SPACE      = 4'd1,
    ST_URL        = 4'd2,
    ST_VERSION    = 4'd3,
    ST_CR         = 4'd4,
    ST_LF         = 4'd5,
    ST_KEY        = 4'd6,
    ST_VALUE      = 4'd7,
    ST_DONE       = 4'd8,
    ST_NOTALLOWED = 4'd9,
    ST_BADREQ     = 4'd10
  } state_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic [7:0]      url_byte;
    logic [LENW-1:0] url_length;
    logic            path_is_root;
  } out_t;

  typedef struct packed {
    state_t         parse_state;
    state_t         resume_state;
    logic [MCW-1:0] method_count;
    logic           method_matches_get;
    logic [UCW-1:0] url_count;
    logic           url_slash_first;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    parse_state:        ST_METHOD,
    resume_state:       ST_METHOD,
    method_count:       '0,
    method_matches_get: 1'b1,
    url_count:          '0,
    url_slash_first:    1'b0
  };

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hrhp_step.sv
`default_nettype none

module hrhp_step (
  input  hrhp_pkg::ctx_t ctx,
  input  hrhp_pkg::in_t  din,
  output hrhp_pkg::ctx_t ctx_nxt,
  output hrhp_pkg::out_t res
);

  hrhp_pkg::state_t               st;
  logic [7:0]                     c;
  logic [hrhp_pkg::MCW-1:0]       method_inc;
  logic [hrhp_pkg::UCW-1:0]       url_inc;
  logic                           method_over;
  logic                           url_over;
  logic                           get_ok;
  logic                           char_miss;
  logic [2:0]                     ev;
  logic [7:0]                     ub;
  logic                           root;

  assign c = din.data_byte;

  // a space run hands its first non-space byte to the state it leads to
  assign st = (ctx.parse_state == hrhp_pkg::ST_SPACE && c != hrhp_pkg::CH_SPACE) ?
              ctx.resume_state : ctx.parse_state;

  assign method_inc  = ctx.method_count + hrhp_pkg::MCW'(1);
  assign url_inc     = ctx.url_count + hrhp_pkg::UCW'(1);
  assign method_over = method_inc > hrhp_pkg::MCW'(hrhp_pkg::METHOD_LIMIT);
  assign url_over    = url_inc > hrhp_pkg::UCW'(hrhp_pkg::URL_LIMIT);
  assign get_ok      = ctx.method_matches_get &&
                       ctx.method_count == hrhp_pkg::MCW'(hrhp_pkg::GET_LEN);
  assign char_miss   = (ctx.method_count >= hrhp_pkg::MCW'(hrhp_pkg::GET_LEN)) ||
                       (c != hrhp_pkg::get_char(ctx.method_count[1:0]));

  always_comb begin
    ctx_nxt = ctx;
    ctx_nxt.parse_state = st;
    if (din.opcode == hrhp_pkg::OP_NEW) begin
      ctx_nxt = hrhp_pkg::CTX_RESET;
    end else begin
      unique case (st) inside
        hrhp_pkg::ST_METHOD: begin
          if (c == hrhp_pkg::CH_SPACE) begin
            if (get_ok) begin
              ctx_nxt.parse_state  = hrhp_pkg::ST_SPACE;
              ctx_nxt.resume_state = hrhp_pkg::ST_URL;
            end else begin
              ctx_nxt.parse_state = hrhp_pkg::ST_NOTALLOWED;
            end
          end else begin
            if (char_miss) begin
              ctx_nxt.method_matches_get = 1'b0;
            end
            ctx_nxt.method_count = method_inc;
            if (method_over) begin
              ctx_nxt.parse_state = hrhp_pkg::ST_BADREQ;
            end
          end
        end
        hrhp_pkg::ST_SPACE: begin
          if (c != hrhp_pkg::CH_SPACE) begin
            ctx_nxt.parse_state = ctx.resume_state;
          end
        end
        hrhp_pkg::ST_URL: begin
          if (c == hrhp_pkg::CH_SPACE) begin
            ctx_nxt.parse_state  = hrhp_pkg::ST_SPACE;
            ctx_nxt.resume_state = hrhp_pkg::ST_VERSION;
          end else begin
            if (ctx.url_count == '0) begin
              ctx_nxt.url_slash_first = (c == hrhp_pkg::CH_SLASH);
            end
            ctx_nxt.url_count = url_inc;
            if (url_over) begin
              ctx_nxt.parse_state = hrhp_pkg::ST_BADREQ;
            end
          end
        end
        hrhp_pkg::ST_VERSION, hrhp_pkg::ST_VALUE: begin
          if (c == hrhp_pkg::CH_CR) begin
            ctx_nxt.parse_state  = hrhp_pkg::ST_CR;
            ctx_nxt.resume_state = hrhp_pkg::ST_KEY;
          end
        end
        hrhp_pkg::ST_CR: begin
          ctx_nxt.parse_state = (c == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_LF : hrhp_pkg::ST_BADREQ;
        end
        hrhp_pkg::ST_LF: begin
          ctx_nxt.parse_state = (c == hrhp_pkg::CH_CR) ? hrhp_pkg::ST_DONE : ctx.resume_state;
        end
        hrhp_pkg::ST_KEY: begin
          if (c == hrhp_pkg::CH_COLON) begin
            ctx_nxt.parse_state  = hrhp_pkg::ST_SPACE;
            ctx_nxt.resume_state = hrhp_pkg::ST_VALUE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ev   = hrhp_pkg::EV_NONE;
    ub   = 8'h00;
    root = 1'b0;
    if (din.opcode == hrhp_pkg::OP_BYTE) begin
      unique case (st)
        hrhp_pkg::ST_METHOD: begin
          if (c == hrhp_pkg::CH_SPACE) begin
            if (!get_ok) begin
              ev = hrhp_pkg::EV_NOTALLOWED;
            end
          end else if (method_over) begin
            ev = hrhp_pkg::EV_BADREQ;
          end
        end
        hrhp_pkg::ST_URL: begin
          if (c != hrhp_pkg::CH_SPACE) begin
            if (url_over) begin
              ev = hrhp_pkg::EV_BADREQ;
            end else begin
              ev = hrhp_pkg::EV_URL;
              ub = c;
            end
          end
        end
        hrhp_pkg::ST_CR: begin
          if (c != hrhp_pkg::CH_LF) begin
            ev = hrhp_pkg::EV_BADREQ;
          end
        end
        hrhp_pkg::ST_LF: begin
          if (c == hrhp_pkg::CH_CR) begin
            ev   = ctx.url_slash_first ? hrhp_pkg::EV_DONE : hrhp_pkg::EV_DONE_BADPATH;
            root = ctx.url_slash_first && ctx.url_count == hrhp_pkg::UCW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.event_res    = ev;
    res.url_byte     = ub;
    res.path_is_root = root;
    if (ctx_nxt.url_count > hrhp_pkg::UCW'(hrhp_pkg::URL_LIMIT)) begin
      res.url_length = hrhp_pkg::LENW'(hrhp_pkg::URL_LIMIT);
    end else begin
      res.url_length = hrhp_pkg::LENW'(ctx_nxt.url_count);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/http_request_head_parser.sv
`default_nettype none

// channel  ports                       payload
// -------  --------------------------  ----------------------------------------
// input    in_valid / in_stall         in_data  (opcode, data_byte)
// result   out_valid / out_stall       out_data (event_res, url_byte,
//                                                url_length, path_is_root)
//
// One result beat per input beat, in order; one beat per cycle sustained while the result is not stalled.
// A beat passes through the input register, then one parser step into the result register.
// The parser step is a single state update on the registered byte.
// A stalled result holds; the input register still takes one more beat behind it.
// rst_n (synchronous) clears the parser context and both valid flags.

module http_request_head_parser (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  hrhp_pkg::in_t    in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output hrhp_pkg::out_t   out_data
);

  hrhp_pkg::in_t  in_r;
  logic           in_valid_r;
  hrhp_pkg::ctx_t ctx_r;
  hrhp_pkg::ctx_t ctx_nxt;
  hrhp_pkg::out_t res;
  hrhp_pkg::out_t out_r;
  logic           out_valid_r;
  logic           advance;
  logic           in_take;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  hrhp_step u_step (
    .ctx     (ctx_r),
    .din     (in_r),
    .ctx_nxt (ctx_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r       <= hrhp_pkg::CTX_RESET;
    end else begin
      in_valid_r  <= in_take || (in_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && out_stall);
      if (advance) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.url_length <= hrhp_pkg::LENW'(hrhp_pkg::URL_LIMIT))
    else $error("url_length above limit");

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path_is_root |-> out_data.event_res == hrhp_pkg::EV_DONE)
    else $error("root flag without head done");

  a_url_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_data.event_res != hrhp_pkg::EV_URL) ||
                (ctx_r.parse_state == hrhp_pkg::ST_URL))
    else $error("url beat outside url state");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.opcode == hrhp_pkg::OP_BYTE && ctx_r.parse_state == hrhp_pkg::ST_DONE
    |=> ctx_r.parse_state == hrhp_pkg::ST_DONE)
    else $error("left done state without new connection");

endmodule

`default_nettype wire
